>>> rtl/core/lz77_token_decoder_top_macros.svh
// Assertion macros used by the decoder top level.
`ifndef LZ77_TOKEN_DECODER_TOP_MACROS_SVH
`define LZ77_TOKEN_DECODER_TOP_MACROS_SVH

// Checked every edge once reset is released.
`define LZD_ASSERT_ON(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked every edge, reset included.
`define LZD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/lzd_pkg.sv
// Shared types and constants of the LZ77 token decoder.
package lzd_pkg;

  localparam int DIST_W      = 13;
  localparam int LEN_IN_W    = 4;
  localparam int BYTE_W      = 8;
  // Saturated length field wide enough for the largest supported MAX_MATCH.
  localparam int LEN_W       = 6;
  localparam int QUEUE_DEPTH = 2;

  localparam int HISTORY_DEPTH_DEF = 4096;
  localparam int MAX_MATCH_DEF     = 15;

  typedef struct packed {
    logic [DIST_W-1:0]   match_distance;
    logic [LEN_IN_W-1:0] match_length;
    logic [BYTE_W-1:0]   next_byte;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last;
    logic              bad_distance;
  } out_item_t;

  // Classified token handed from front to back.
  typedef struct packed {
    logic [DIST_W-1:0] match_distance;
    logic [LEN_W-1:0]  match_length;
    logic              dist_zero;
    logic [BYTE_W-1:0] next_byte;
  } cmd_t;

endpackage

>>> rtl/core/lzd_front.sv
// Front end: takes tokens, saturates the length, flags a zero distance.
module lzd_front #(
  parameter int MAX_MATCH = lzd_pkg::MAX_MATCH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  lzd_pkg::in_item_t in_item,
  output logic             push_valid,
  input  logic             push_ready,
  output lzd_pkg::cmd_t    push_cmd
);

  logic          hold_valid_r;
  lzd_pkg::cmd_t hold_cmd_r;
  lzd_pkg::cmd_t cls_cmd;
  logic [lzd_pkg::LEN_W-1:0] len_ext;

  always_comb begin
    len_ext = lzd_pkg::LEN_W'(in_item.match_length);
    cls_cmd.match_distance = in_item.match_distance;
    cls_cmd.match_length   = (len_ext > lzd_pkg::LEN_W'(MAX_MATCH)) ?
                             lzd_pkg::LEN_W'(MAX_MATCH) : len_ext;
    cls_cmd.dist_zero      = (in_item.match_distance == '0);
    cls_cmd.next_byte      = in_item.next_byte;
  end

  assign in_ready   = !hold_valid_r || push_ready;
  assign push_valid = hold_valid_r;
  assign push_cmd   = hold_cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        hold_valid_r <= 1'b1;
        hold_cmd_r   <= cls_cmd;
      end else if (push_ready) begin
        hold_valid_r <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/core/lzd_queue.sv
// Small FIFO of classified tokens between front and back.
module lzd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  lzd_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop,
  output lzd_pkg::cmd_t pop_cmd
);

  localparam int PTR_W = (lzd_pkg::QUEUE_DEPTH > 1) ? $clog2(lzd_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(lzd_pkg::QUEUE_DEPTH + 1);

  lzd_pkg::cmd_t     slot_r [lzd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count_r != CNT_W'(lzd_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == PTR_W'(lzd_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (do_push && !do_pop) count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

endmodule

>>> rtl/core/lzd_back.sv
// Back end: copy engine over the history memory, plus the output register.
module lzd_back #(
  parameter int HISTORY_DEPTH = lzd_pkg::HISTORY_DEPTH_DEF,
  parameter int MAX_MATCH     = lzd_pkg::MAX_MATCH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_pop,
  input  lzd_pkg::cmd_t      cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output lzd_pkg::out_item_t out_item
);

  localparam int PW = $clog2(HISTORY_DEPTH);
  localparam int FW = $clog2(HISTORY_DEPTH + 1);
  localparam int CW = $clog2(MAX_MATCH + 1);
  localparam int XW = (FW > lzd_pkg::DIST_W) ? FW : lzd_pkg::DIST_W;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_READ,
    ST_COPY,
    ST_LIT
  } state_t;

  state_t                    state_r;
  logic [lzd_pkg::DIST_W-1:0] dist_r;
  logic                      dist_zero_r;
  logic [lzd_pkg::BYTE_W-1:0] lit_r;
  logic [CW-1:0]             rem_r;
  logic                      bad_r;
  logic [PW-1:0]             wp_r;
  logic [FW-1:0]             filled_r;
  logic                      out_valid_r;
  lzd_pkg::out_item_t        out_item_r;

  logic [lzd_pkg::BYTE_W-1:0] hist_mem_r [HISTORY_DEPTH];
  logic [lzd_pkg::BYTE_W-1:0] rd_data_r;

  logic                      slot_free;
  logic                      wr_en;
  logic [lzd_pkg::BYTE_W-1:0] wr_data;
  logic                      dist_ok;
  logic [PW:0]               wp_ext;
  logic [PW:0]               d_ext;
  logic [PW-1:0]             rd_addr;
  logic [PW-1:0]             wp_inc;

  assign slot_free = !out_valid_r || out_ready;
  assign cmd_pop   = (state_r == ST_LOAD) && cmd_valid;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Distance test is redone for every copied byte, as filled_r grows.
  assign dist_ok = !dist_zero_r && (XW'(dist_r) <= XW'(filled_r));

  always_comb begin
    wp_ext  = (PW + 1)'(wp_r);
    d_ext   = (PW + 1)'(dist_r);
    rd_addr = (wp_ext >= d_ext) ? PW'(wp_ext - d_ext)
                                : PW'(wp_ext + (PW + 1)'(HISTORY_DEPTH) - d_ext);
    wp_inc  = (wp_r == PW'(HISTORY_DEPTH - 1)) ? '0 : wp_r + 1'b1;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_data = lit_r;
    unique case (state_r)
      ST_COPY: begin
        wr_en   = slot_free;
        wr_data = bad_r ? '0 : rd_data_r;
      end
      ST_LIT: begin
        wr_en   = slot_free;
        wr_data = lit_r;
      end
      ST_LOAD, ST_READ: begin
        wr_en   = 1'b0;
      end
      default: begin
        wr_en   = 1'b0;
      end
    endcase
  end

  // History ring: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist_mem_r[wp_r] <= wr_data;
    end
    if (state_r == ST_READ) begin
      rd_data_r <= hist_mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      wp_r        <= '0;
      filled_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        wp_r        <= wp_inc;
        if (filled_r != FW'(HISTORY_DEPTH)) filled_r <= filled_r + 1'b1;
        out_valid_r <= 1'b1;
        out_item_r.out_byte     <= wr_data;
        out_item_r.last         <= (state_r == ST_LIT);
        out_item_r.bad_distance <= (state_r == ST_COPY) && bad_r;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_LOAD: begin
          if (cmd_valid) begin
            dist_r      <= cmd.match_distance;
            dist_zero_r <= cmd.dist_zero;
            lit_r       <= cmd.next_byte;
            rem_r       <= CW'(cmd.match_length);
            state_r     <= (cmd.match_length != '0) ? ST_READ : ST_LIT;
          end
        end
        ST_READ: begin
          bad_r   <= !dist_ok;
          state_r <= ST_COPY;
        end
        ST_COPY: begin
          if (slot_free) begin
            rem_r   <= rem_r - 1'b1;
            state_r <= (rem_r == CW'(1)) ? ST_LIT : ST_READ;
          end
        end
        ST_LIT: begin
          if (slot_free) state_r <= ST_LOAD;
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

endmodule

>>> rtl/core/lz77_token_decoder_top.sv
// Top level of the LZ77 token decoder: front end, token queue, copy engine.
//
//  channel  | dir | handshake            | payload
//  in_      | in  | in_valid / in_ready  | in_item  (distance, length, literal)
//  out_     | out | out_valid / out_ready| out_item (byte, last, bad_distance)
//
// While a token of length L is in the copy engine, each copied byte takes a
// read on the registered history read port and then a write/emit step,
// followed by one step for the literal and one to load the next token.
// Reset (rst_n low, synchronous) empties the queue and output register and
// zeroes the write pointer and fill count; history contents are not cleared.
// A stalled output holds the engine; the front register and two-entry queue
// keep taking tokens until full.
module lz77_token_decoder_top #(
  parameter int HISTORY_DEPTH = lzd_pkg::HISTORY_DEPTH_DEF,
  parameter int MAX_MATCH     = lzd_pkg::MAX_MATCH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lzd_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output lzd_pkg::out_item_t out_item
);

  `include "lz77_token_decoder_top_macros.svh"

  logic          f_push_valid;
  logic          f_push_ready;
  lzd_pkg::cmd_t f_push_cmd;
  logic          q_valid;
  logic          q_pop;
  lzd_pkg::cmd_t q_cmd;

  lzd_front #(
    .MAX_MATCH (MAX_MATCH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .push_valid (f_push_valid),
    .push_ready (f_push_ready),
    .push_cmd   (f_push_cmd)
  );

  lzd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_push_valid),
    .push_ready (f_push_ready),
    .push_cmd   (f_push_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  lzd_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .MAX_MATCH     (MAX_MATCH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_pop   (q_pop),
    .cmd       (q_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  `LZD_ASSERT_ON(a_lit_never_bad, out_valid |-> !(out_item.last && out_item.bad_distance), "literal flagged bad")
  `LZD_ASSERT_ON(a_front_blocks_when_full, (f_push_valid && !f_push_ready) |-> !in_ready, "front took item while queue full")
  `LZD_ASSERT_ON(a_pop_only_valid, q_pop |-> q_valid, "engine popped empty queue")
  `LZD_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid, "output valid after reset")

endmodule
